FILE: hw/rtl/brm_pkg.sv
// brm_pkg: shared constants, widths and the controller-to-datapath command
// struct for the block rms meter; used by every other file of the block
`timescale 1ns / 1ps

package brm_pkg;

    // fixed field widths of the ports
    localparam int SAMPLE_W = 16;
    localparam int RMS_W    = 16;

    // sizing constants
    localparam int MAX_SAMPLES = 65536;
    localparam int SAMPLE_BITS = 16;

    // square of a full-scale sample needs 2*(bits-1)+1 bits (max 2^(2*bits-2))
    localparam int SQ_W   = 2 * (SAMPLE_BITS - 1) + 1;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = SQ_W + CNT_W - 1;
    // mean square never exceeds the largest square; kept even for the root
    localparam int MEAN_W = SQ_W + 1;
    localparam int ROOT_STEPS = MEAN_W / 2;
    localparam int DIV_STEPS  = SUM_W;
    localparam int STEP_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic acc_en;     // accumulate the accepted word
        logic div_load;   // move sum and count into the divider, clear accumulators
        logic div_step;   // one restoring divide step
        logic sqrt_load;  // move the quotient into the root unit
        logic sqrt_step;  // one root step
        logic out_load;   // capture the result into the output register
    } brm_cmd_t;

endpackage

FILE: hw/rtl/brm_in_if.sv
// brm_in_if: input channel of the block rms meter (valid/ready, sample word)
// depends on brm_pkg for the sample width
`timescale 1ns / 1ps

interface brm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [brm_pkg::SAMPLE_W-1:0]  sample;
    logic                                 block_end;

    modport source (output valid, output sample, output block_end, input ready);
    modport sink (input valid, input sample, input block_end, output ready);
endinterface

FILE: hw/rtl/brm_out_if.sv
// brm_out_if: result channel of the block rms meter (valid/ready, level word)
// depends on brm_pkg for the level width
`timescale 1ns / 1ps

interface brm_out_if;
    logic                         valid;
    logic                         ready;
    logic [brm_pkg::RMS_W-1:0]    rms_level;
    logic                         overflow;

    modport source (output valid, output rms_level, output overflow, input ready);
    modport sink (input valid, input rms_level, input overflow, output ready);
endinterface

FILE: hw/rtl/block_rms_meter.sv
// block_rms_meter: top level of the block rms level meter; joins the
// controller brm_ctrl and the datapath brm_datapath; depends on brm_pkg and the channel interfaces
`timescale 1ns / 1ps

// Block RMS level meter. Signed Q1.15 samples of any channel arrive on the
// samples channel, one word per cycle; each is squared and added to a running
// sum while a counter tracks the block length. The word with block_end set is
// the last of the block: it is accumulated too, then the sum is divided by the
// count (floor) in a one-bit-per-cycle restoring divider and the floor square
// root of that mean is found two bits per cycle. The result word carries the
// unsigned Q1.15 level (0 to 32768) and an overflow flag. Throughput is one
// sample per cycle inside a block; after a block_end word the input stalls
// through load, divide, load, root and hand-off, and longer only if the
// previous result word is still waiting on the levels channel. A block longer
// than 65536 samples keeps the first 65536, drops the rest and reports
// overflow; the marking word still closes the block.
module block_rms_meter
(
    input  logic      clk,
    input  logic      rst_n,
    brm_in_if.sink    samples,
    brm_out_if.source levels
);

    brm_pkg::brm_cmd_t cmd;
    logic              in_fire;
    logic              out_fire;
    logic              in_ready;
    logic              out_valid;

    assign in_fire  = samples.valid && in_ready;
    assign out_fire = out_valid && levels.ready;

    assign samples.ready = in_ready;
    assign levels.valid  = out_valid;

    // sequencer
    brm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_last   (samples.block_end),
        .out_fire  (out_fire),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // accumulate, divide, root and result register
    brm_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample    (samples.sample),
        .rms_level (levels.rms_level),
        .overflow  (levels.overflow)
    );

`ifndef SYNTH
    // a closing word stops intake while the result is computed
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && samples.block_end |=> !samples.ready)
        else $error("input still ready after block end word");

    // the level never exceeds full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        levels.valid |-> (levels.rms_level <= 16'h8000))
        else $error("rms level above full scale");

    // the controller issues at most one datapath command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.acc_en, cmd.div_load, cmd.div_step, cmd.sqrt_load,
                  cmd.sqrt_step, cmd.out_load}))
        else $error("overlapping datapath commands");
`endif

endmodule

FILE: hw/rtl/brm_ctrl.sv
// brm_ctrl: sequencer for the block rms meter; runs accumulate, divide,
// square root and result hand-off; depends on brm_pkg
`timescale 1ns / 1ps

module brm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              in_last,
    input  logic              out_fire,
    output logic              in_ready,
    output logic              out_valid,
    output brm_pkg::brm_cmd_t cmd
);

    localparam logic [2:0] ST_ACC  = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SQL  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [brm_pkg::STEP_W-1:0]  step_reg;
    logic [brm_pkg::STEP_W-1:0]  step_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_fire;
        case (state_reg)
            ST_ACC:
            begin
                in_ready   = 1'b1;
                cmd.acc_en = in_fire;
                if (in_fire && in_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == brm_pkg::STEP_W'(brm_pkg::DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_SQL;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_SQL:
            begin
                cmd.sqrt_load = 1'b1;
                step_next     = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == brm_pkg::STEP_W'(brm_pkg::ROOT_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                // wait until the previous result word has left
                if (!out_valid_reg || out_fire)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/brm_datapath.sv
// brm_datapath: square accumulator, bit-serial restoring divider, bit-pair
// square root and result register; driven by brm_ctrl, depends on brm_pkg
`timescale 1ns / 1ps

module brm_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  brm_pkg::brm_cmd_t             cmd,
    input  logic [brm_pkg::SAMPLE_W-1:0]  sample,
    output logic [brm_pkg::RMS_W-1:0]     rms_level,
    output logic                          overflow
);

    localparam int SB = brm_pkg::SAMPLE_BITS;
    localparam int MW = brm_pkg::MEAN_W;

    // accumulators
    logic [brm_pkg::SUM_W-1:0]  sum_reg;
    logic [brm_pkg::CNT_W-1:0]  cnt_reg;
    logic                       ovf_reg;

    // divider
    logic [brm_pkg::SUM_W-1:0]  dvd_reg;
    logic [brm_pkg::CNT_W-1:0]  rem_reg;
    logic [brm_pkg::CNT_W-1:0]  dsr_reg;
    logic                       ovf_hold_reg;

    // root unit
    logic [MW-1:0]              val_reg;
    logic [MW-1:0]              root_reg;
    logic [MW-1:0]              rbit_reg;

    // output word
    logic [brm_pkg::RMS_W-1:0]  rms_reg;
    logic                       ovf_out_reg;

    logic [SB-1:0]              raw;
    logic [SB-1:0]              mag;
    logic [2*SB-1:0]            sq_full;
    logic [brm_pkg::SQ_W-1:0]   sq;
    logic                       cnt_full;
    logic [brm_pkg::CNT_W:0]    trial;
    logic                       trial_ge;
    logic [brm_pkg::CNT_W:0]    trial_sub;
    logic [MW:0]                rtry;
    logic                       rtry_ge;
    logic [MW-1:0]              mean;

    // magnitude of the sample; the most negative code maps to 2^(bits-1)
    assign raw      = sample[SB-1:0];
    assign mag      = raw[SB-1] ? (~raw + 1'b1) : raw;
    assign sq_full  = mag * mag;
    assign sq       = sq_full[brm_pkg::SQ_W-1:0];
    assign cnt_full = (cnt_reg >= brm_pkg::CNT_W'(brm_pkg::MAX_SAMPLES));

    // restoring divide step: shift in the next dividend bit
    assign trial     = {rem_reg, dvd_reg[brm_pkg::SUM_W-1]};
    assign trial_ge  = (trial >= {1'b0, dsr_reg});
    assign trial_sub = trial - {1'b0, dsr_reg};

    // root step
    assign rtry    = {1'b0, root_reg} + {1'b0, rbit_reg};
    assign rtry_ge = ({1'b0, val_reg} >= rtry);

    // empty count gives a zero mean
    assign mean = (dsr_reg == '0) ? '0 : dvd_reg[MW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.div_load)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.acc_en)
        begin
            if (!cnt_full)
            begin
                sum_reg <= sum_reg + brm_pkg::SUM_W'(sq);
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dvd_reg      <= sum_reg;
            rem_reg      <= '0;
            dsr_reg      <= cnt_reg;
            ovf_hold_reg <= ovf_reg;
        end
        else if (cmd.div_step)
        begin
            if (trial_ge)
            begin
                rem_reg <= trial_sub[brm_pkg::CNT_W-1:0];
            end
            else
            begin
                rem_reg <= trial[brm_pkg::CNT_W-1:0];
            end
            dvd_reg <= {dvd_reg[brm_pkg::SUM_W-2:0], trial_ge};
        end

        if (cmd.sqrt_load)
        begin
            val_reg  <= mean;
            root_reg <= '0;
            rbit_reg <= MW'(1) << (MW - 2);
        end
        else if (cmd.sqrt_step)
        begin
            if (rtry_ge)
            begin
                val_reg  <= val_reg - rtry[MW-1:0];
                root_reg <= (root_reg >> 1) + rbit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            rbit_reg <= rbit_reg >> 2;
        end

        if (cmd.out_load)
        begin
            rms_reg     <= root_reg[brm_pkg::RMS_W-1:0];
            ovf_out_reg <= ovf_hold_reg;
        end
    end

    assign rms_level = rms_reg;
    assign overflow  = ovf_out_reg;

endmodule
